// ===== hw/rtl/intel_hex_record_parser_assert.svh =====
// assertion macros for the intel hex record parser
// no dependencies; the bodies are empty when SYNTH is defined
`ifndef INTEL_HEX_RECORD_PARSER_ASSERT_SVH
`define INTEL_HEX_RECORD_PARSER_ASSERT_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define IHX_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define IHX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define IHX_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define IHX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/ihx_pkg.sv =====
// shared types, codes and helpers for the intel hex record parser
// no dependencies
`default_nettype none

package ihx_pkg;

	localparam int IMAGE_BYTES = 1048576;
	localparam int ADDR_W      = 20;

	localparam logic [2:0] KIND_WRITE = 3'd0;
	localparam logic [2:0] KIND_OK    = 3'd1;
	localparam logic [2:0] KIND_OTHER = 3'd2;
	localparam logic [2:0] KIND_EOF   = 3'd3;
	localparam logic [2:0] KIND_ERROR = 3'd4;

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;

	localparam logic [ADDR_W-1:0] TOTAL_MAX = '1;

	typedef struct packed {
		logic [2:0]        kind;
		logic [ADDR_W-1:0] address;
		logic [7:0]        data;
		logic [ADDR_W-1:0] total_bytes;
	} result_t;

	// bit 4 set means not a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] v;
		v = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = {1'b0, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = {1'b0, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = {1'b0, 4'(c - 8'h57)};
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ihx_char_if.sv =====
// character channel of the intel hex record parser
// no dependencies
`default_nettype none

interface ihx_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink   (input valid, input char_in, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ihx_rec_if.sv =====
// result channel of the intel hex record parser
// depends on ihx_pkg for the address width
`default_nettype none

interface ihx_rec_if;
	logic                      valid;
	logic                      ready;
	logic [2:0]                kind;
	logic [ihx_pkg::ADDR_W-1:0] address;
	logic [7:0]                data;
	logic [ihx_pkg::ADDR_W-1:0] total_bytes;

	modport source (output valid, output kind, output address, output data,
		output total_bytes, input ready);
	modport sink   (input valid, input kind, input address, input data,
		input total_bytes, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/intel_hex_record_parser.sv =====
// intel hex record parser: one character register, one parse step, one result register
// path: character register, parse step, result register; a held word stalls the step
// throughput: one character per cycle while results are taken, bounded by the single-step update
// reset: arst_n clears the parse state, the byte total and the stop latch at once
// depends on ihx_pkg, ihx_char_if, ihx_rec_if and intel_hex_record_parser_assert.svh
`default_nettype none
`include "intel_hex_record_parser_assert.svh"

module intel_hex_record_parser #(
	parameter int IMAGE_BYTES = ihx_pkg::IMAGE_BYTES
) (
	input  wire        clk,
	input  wire        arst_n,
	ihx_char_if.sink   chars,
	ihx_rec_if.source  records
);
	import ihx_pkg::*;

	localparam logic [2:0] PH_COLON   = 3'd0;
	localparam logic [2:0] PH_LEN     = 3'd1;
	localparam logic [2:0] PH_ADDR_HI = 3'd2;
	localparam logic [2:0] PH_ADDR_LO = 3'd3;
	localparam logic [2:0] PH_TYPE    = 3'd4;
	localparam logic [2:0] PH_DATA    = 3'd5;
	localparam logic [2:0] PH_SUM     = 3'd6;
	localparam logic [2:0] PH_EOL     = 3'd7;

	localparam logic [ADDR_W:0] IMAGE_LIMIT = (ADDR_W + 1)'(IMAGE_BYTES);

	// input stage
	logic       valid_s1;
	logic [7:0] char_s1;

	// parser state
	logic [2:0]        phase_q, phase_d;
	logic [3:0]        nib_q, nib_d;
	logic              half_q, half_d;
	logic [7:0]        len_q, len_d;
	logic [15:0]       addr_q, addr_d;
	logic [7:0]        type_q, type_d;
	logic [7:0]        sum_q, sum_d;
	logic [7:0]        done_q, done_d;
	logic [ADDR_W-1:0] total_q, total_d;
	logic              stopped_q, stopped_d;

	// output register
	logic    out_valid_q;
	result_t out_q;

	logic    advance;
	logic    res_valid;
	result_t res;

	logic       eol;
	logic [4:0] dv;
	logic [7:0] byte_val;
	logic [7:0] sum_new;
	logic [7:0] done_inc;

	assign advance     = valid_s1 && (!out_valid_q || records.ready);
	assign chars.ready = !valid_s1 || advance;

	assign eol      = (char_s1 == CHAR_CR) || (char_s1 == CHAR_LF);
	assign dv       = hex_digit(char_s1);
	assign byte_val = {nib_q, dv[3:0]};
	assign sum_new  = sum_q + byte_val;
	assign done_inc = done_q + 8'd1;

	always_comb begin
		phase_d   = phase_q;
		nib_d     = nib_q;
		half_d    = half_q;
		len_d     = len_q;
		addr_d    = addr_q;
		type_d    = type_q;
		sum_d     = sum_q;
		done_d    = done_q;
		total_d   = total_q;
		stopped_d = stopped_q;
		res_valid = 1'b0;
		res.kind    = KIND_ERROR;
		res.address = '0;
		res.data    = '0;

		if (!stopped_q) begin
			unique case (phase_q)
				PH_COLON: begin
					if (!eol) begin
						if (char_s1 != CHAR_COLON) begin
							res_valid = 1'b1;
							stopped_d = 1'b1;
						end else begin
							half_d  = 1'b0;
							nib_d   = '0;
							sum_d   = '0;
							done_d  = '0;
							len_d   = '0;
							addr_d  = '0;
							type_d  = '0;
							phase_d = PH_LEN;
						end
					end
				end
				PH_EOL: begin
					if (eol) begin
						phase_d   = PH_COLON;
						res_valid = 1'b1;
						if (type_q == 8'h00) begin
							res.kind = KIND_OK;
						end else if (type_q == 8'h01) begin
							res.kind  = KIND_EOF;
							stopped_d = 1'b1;
						end else begin
							res.kind = KIND_OTHER;
						end
					end
				end
				default: begin
					if (eol || dv[4]) begin
						res_valid = 1'b1;
						stopped_d = 1'b1;
					end else if (!half_q) begin
						nib_d  = dv[3:0];
						half_d = 1'b1;
					end else begin
						half_d = 1'b0;
						sum_d  = sum_new;
						case (phase_q)
							PH_LEN: begin
								len_d   = byte_val;
								phase_d = PH_ADDR_HI;
							end
							PH_ADDR_HI: begin
								addr_d  = {byte_val, 8'h00};
								phase_d = PH_ADDR_LO;
							end
							PH_ADDR_LO: begin
								addr_d  = {addr_q[15:8], byte_val};
								phase_d = PH_TYPE;
							end
							PH_TYPE: begin
								type_d = byte_val;
								if (byte_val == 8'h00 &&
									((ADDR_W + 1)'(addr_q) + (ADDR_W + 1)'(len_q)) > IMAGE_LIMIT) begin
									res_valid = 1'b1;
									stopped_d = 1'b1;
								end else begin
									done_d  = '0;
									phase_d = (len_q != 8'h00) ? PH_DATA : PH_SUM;
								end
							end
							PH_DATA: begin
								done_d = done_inc;
								if (done_inc == len_q) begin
									phase_d = PH_SUM;
								end
								if (type_q == 8'h00) begin
									if (total_q != TOTAL_MAX) begin
										total_d = total_q + 1'b1;
									end
									res_valid   = 1'b1;
									res.kind    = KIND_WRITE;
									res.address = ADDR_W'(addr_q) + ADDR_W'(done_q);
									res.data    = byte_val;
								end
							end
							PH_SUM: begin
								if (sum_new != 8'h00) begin
									res_valid = 1'b1;
									stopped_d = 1'b1;
								end else begin
									phase_d = PH_EOL;
								end
							end
							default: begin
								phase_d   = PH_COLON;
								res_valid = 1'b1;
								stopped_d = 1'b1;
							end
						endcase
					end
				end
			endcase
		end
		res.total_bytes = total_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_COLON;
			nib_q     <= '0;
			half_q    <= 1'b0;
			len_q     <= '0;
			addr_q    <= '0;
			type_q    <= '0;
			sum_q     <= '0;
			done_q    <= '0;
			total_q   <= '0;
			stopped_q <= 1'b0;
		end else if (advance) begin
			phase_q   <= phase_d;
			nib_q     <= nib_d;
			half_q    <= half_d;
			len_q     <= len_d;
			addr_q    <= addr_d;
			type_q    <= type_d;
			sum_q     <= sum_d;
			done_q    <= done_d;
			total_q   <= total_d;
			stopped_q <= stopped_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (records.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign records.valid       = out_valid_q;
	assign records.kind        = out_q.kind;
	assign records.address     = out_q.address;
	assign records.data        = out_q.data;
	assign records.total_bytes = out_q.total_bytes;

	// once stopped, no new word may appear on the result side
	`IHX_ASSERT_NEXT(a_stop_quiet, clk, arst_n, stopped_q && !out_valid_q, !out_valid_q,
		"result produced after stop")
	// the byte total never goes backwards
	`IHX_ASSERT_NEXT(a_total_mono, clk, arst_n, 1'b1, total_q >= $past(total_q),
		"byte total decreased")
	// write words stay inside the image
	`IHX_ASSERT_SAME(a_write_range, clk, arst_n, out_valid_q && out_q.kind == KIND_WRITE,
		(ADDR_W + 1)'(out_q.address) < IMAGE_LIMIT, "write outside image")
	// non-write words carry zero address and data
	`IHX_ASSERT_SAME(a_status_zero, clk, arst_n, out_valid_q && out_q.kind != KIND_WRITE,
		out_q.address == '0 && out_q.data == '0, "status word with payload")

endmodule

`default_nettype wire
